@@ design/lcdseq_pkg.sv @@
`timescale 1ns / 1ps

package lcdseq_pkg;

	// input opcodes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// process modes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// source of the data pins for a result
	localparam logic [1:0] DSEL_KEEP  = 2'd0;
	localparam logic [1:0] DSEL_CONST = 2'd1;
	localparam logic [1:0] DSEL_MEM   = 2'd2;

	// LCD commands and timing
	localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
	localparam logic [7:0] CMD_CLEAR        = 8'h01;
	localparam logic [5:0] POWER_UP_MS      = 6'd40;
	localparam logic [5:0] PULSE_HIGH_MS    = 6'd1;
	localparam logic [5:0] PULSE_LOW_MS     = 6'd2;

	// last step of the power-up run
	localparam logic [2:0] INIT_LAST_STEP = 3'd6;

	// one accepted item as it leaves the control stage
	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic       e;
		logic [1:0] data_sel;
		logic [7:0] data_const;
		logic       status;
		logic       done;
	} lcdseq_rec_t;

	// one result item
	typedef struct packed {
		logic       rs;
		logic       rw;
		logic       e;
		logic [7:0] data;
		logic [5:0] hold;
		logic       status;
		logic       done;
		logic       last;
	} lcdseq_res_t;

	// step of the power-up run; step 0 keeps the data pins, filled in by the caller
	function automatic lcdseq_res_t init_step(input logic [2:0] step);
		lcdseq_res_t r;
		r = '0;
		case (step)
			3'd0: begin
				r.hold = POWER_UP_MS;
			end
			3'd1: begin
				r.e = 1'b1; r.data = CMD_FUNCTION_SET; r.hold = PULSE_HIGH_MS;
			end
			3'd2: begin
				r.data = CMD_FUNCTION_SET; r.hold = PULSE_LOW_MS;
			end
			3'd3: begin
				r.e = 1'b1; r.data = CMD_DISPLAY_ON; r.hold = PULSE_HIGH_MS;
			end
			3'd4: begin
				r.data = CMD_DISPLAY_ON; r.hold = PULSE_LOW_MS;
			end
			3'd5: begin
				r.e = 1'b1; r.data = CMD_CLEAR; r.hold = PULSE_HIGH_MS;
			end
			3'd6: begin
				r.data = CMD_CLEAR; r.hold = PULSE_LOW_MS; r.last = 1'b1;
			end
			default: begin
				r = '0;
			end
		endcase
		return r;
	endfunction

endpackage

@@ design/lcdseq_if.sv @@
`timescale 1ns / 1ps

// request channel
interface lcdseq_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] char_value;
	logic       last_char;

	modport source (output valid, opcode, char_value, last_char, input ready);
	modport sink (input valid, opcode, char_value, last_char, output ready);
endinterface

// pin result channel
interface lcdseq_out_if;
	logic       valid;
	logic       ready;
	logic       reg_select;
	logic       read_write;
	logic       enable_pin;
	logic [7:0] data_bus;
	logic [5:0] hold_ms;
	logic       status;
	logic       write_done;
	logic       last_result;

	modport source (output valid, reg_select, read_write, enable_pin, data_bus, hold_ms,
		status, write_done, last_result, input ready);
	modport sink (input valid, reg_select, read_write, enable_pin, data_bus, hold_ms,
		status, write_done, last_result, output ready);
endinterface

@@ design/lcdseq_buf.sv @@
`timescale 1ns / 1ps

// text buffer: one write port, one read port, registered read data
module lcdseq_buf #(
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/lcdseq_ctrl.sv @@
`timescale 1ns / 1ps

// control stage: decodes each transfer, updates the process state and
// issues the buffer access; holds one decoded item until the emitter takes it
module lcdseq_ctrl import lcdseq_pkg::*; #(
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	lcdseq_in_if.sink     in_ch,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	output logic          valid_s1,
	output lcdseq_rec_t   rec_s1,
	input  logic          take_s1
);

	logic          notify_q;
	logic          init_done_q, init_done_n;
	logic [1:0]    mode_q, mode_n;
	logic          pending_q, pending_n;
	logic [CW-1:0] load_cnt_q, load_cnt_n;
	logic [CW-1:0] text_len_q, text_len_n;
	logic [CW-1:0] send_idx_q, send_idx_n;
	logic          rs_q, rs_n;
	logic          e_q, e_n;
	logic          accept;
	logic          produce;
	logic          valid_s1_q;
	lcdseq_rec_t   rec;

	assign in_ch.ready = !valid_s1_q || take_s1;
	assign accept      = in_ch.valid && in_ch.ready;
	assign valid_s1    = valid_s1_q;
	assign mem_waddr   = load_cnt_q[AW-1:0];
	assign mem_wdata   = in_ch.char_value;
	assign mem_raddr   = send_idx_q[AW-1:0];

	// decode and next state
	always_comb begin
		init_done_n = init_done_q;
		mode_n      = mode_q;
		pending_n   = pending_q;
		load_cnt_n  = load_cnt_q;
		text_len_n  = text_len_q;
		send_idx_n  = send_idx_q;
		rs_n        = rs_q;
		e_n         = e_q;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		produce     = 1'b0;
		rec         = '0;
		rec.data_sel = DSEL_KEEP;
		if (accept) begin
			produce = 1'b1;
			case (in_ch.opcode)
				OP_TICK: begin
					if (!init_done_q) begin
						init_done_n     = 1'b1;
						rs_n            = 1'b0;
						e_n             = 1'b0;
						rec.is_init     = 1'b1;
						rec.data_sel    = DSEL_CONST;
						rec.data_const  = CMD_CLEAR;
					end else begin
						case (mode_q)
							MODE_WRITE: begin
								if (e_q) begin
									e_n = 1'b0;
								end else if (send_idx_q >= text_len_q) begin
									mode_n     = MODE_IDLE;
									pending_n  = 1'b0;
									send_idx_n = '0;
									rec.done   = notify_q;
								end else begin
									rs_n         = 1'b1;
									e_n          = 1'b1;
									rec.data_sel = DSEL_MEM;
									mem_re       = 1'b1;
									send_idx_n   = send_idx_q + CW'(1);
								end
							end
							MODE_CLEAR: begin
								if (e_q) begin
									e_n    = 1'b0;
									mode_n = MODE_IDLE;
								end else begin
									rs_n           = 1'b0;
									e_n            = 1'b1;
									rec.data_sel   = DSEL_CONST;
									rec.data_const = CMD_CLEAR;
								end
							end
							default: begin
							end
						endcase
					end
				end
				OP_WRITE: begin
					if (mode_q != MODE_IDLE) begin
						rec.status = 1'b1;
					end else begin
						pending_n = 1'b1;
						if (load_cnt_q < CW'(DEPTH)) begin
							mem_we     = 1'b1;
							load_cnt_n = load_cnt_q + CW'(1);
						end
						if (in_ch.last_char) begin
							text_len_n = load_cnt_n;
							send_idx_n = '0;
							load_cnt_n = '0;
							mode_n     = MODE_WRITE;
						end
					end
				end
				OP_CLEAR: begin
					if (mode_q != MODE_IDLE || pending_q) begin
						rec.status = 1'b1;
					end else begin
						mode_n = MODE_CLEAR;
					end
				end
				default: begin
					// unused opcode: no result
					produce = 1'b0;
				end
			endcase
		end
		rec.rs = rs_n;
		rec.e  = e_n;
	end

	// process state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notify_q    <= 1'b0;
			init_done_q <= 1'b0;
			mode_q      <= MODE_IDLE;
			pending_q   <= 1'b0;
			load_cnt_q  <= '0;
			text_len_q  <= '0;
			send_idx_q  <= '0;
			rs_q        <= 1'b0;
			e_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				notify_q <= cfg_wdata;
			end
			init_done_q <= init_done_n;
			mode_q      <= mode_n;
			pending_q   <= pending_n;
			load_cnt_q  <= load_cnt_n;
			text_len_q  <= text_len_n;
			send_idx_q  <= send_idx_n;
			rs_q        <= rs_n;
			e_q         <= e_n;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (accept) begin
			valid_s1_q <= produce;
		end else if (take_s1) begin
			valid_s1_q <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept && produce) begin
			rec_s1 <= rec;
		end
	end

endmodule

@@ design/lcdseq_emit.sv @@
`timescale 1ns / 1ps

// result stage: resolves the data pins, runs the power-up steps and
// queues results in a two-entry output buffer
module lcdseq_emit import lcdseq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  lcdseq_rec_t   rec_s1,
	input  logic [7:0]    mem_rdata,
	output logic          take_s1,
	lcdseq_out_if.source  out_ch
);

	logic [7:0]  pin_data_q;
	logic [2:0]  step_q;
	logic [1:0]  cnt_q;
	lcdseq_res_t head_q, tail_q;
	lcdseq_res_t res;
	logic [7:0]  data_now;
	logic        push;
	logic        pop;

	assign push    = valid_s1 && (cnt_q != 2'd2);
	assign pop     = out_ch.valid && out_ch.ready;
	assign take_s1 = push && (!rec_s1.is_init || step_q == INIT_LAST_STEP);

	// data pins after this item
	always_comb begin
		case (rec_s1.data_sel)
			DSEL_CONST: data_now = rec_s1.data_const;
			DSEL_MEM:   data_now = mem_rdata;
			default:    data_now = pin_data_q;
		endcase
	end

	// result build
	always_comb begin
		if (rec_s1.is_init) begin
			res = init_step(step_q);
			if (step_q == 3'd0) begin
				res.data = pin_data_q;
			end
		end else begin
			res        = '0;
			res.rs     = rec_s1.rs;
			res.e      = rec_s1.e;
			res.data   = data_now;
			res.status = rec_s1.status;
			res.done   = rec_s1.done;
			res.last   = 1'b1;
		end
	end

	// power-up step count and data pin state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= 3'd0;
			pin_data_q <= 8'h00;
		end else begin
			if (push && rec_s1.is_init) begin
				step_q <= (step_q == INIT_LAST_STEP) ? 3'd0 : step_q + 3'd1;
			end
			if (take_s1) begin
				pin_data_q <= data_now;
			end
		end
	end

	// output buffer occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// output buffer entries
	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				head_q <= tail_q;
			end else if (push) begin
				head_q <= res;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= res;
			end else begin
				tail_q <= res;
			end
		end
	end

	assign out_ch.valid       = (cnt_q != 2'd0);
	assign out_ch.reg_select  = head_q.rs;
	assign out_ch.read_write  = head_q.rw;
	assign out_ch.enable_pin  = head_q.e;
	assign out_ch.data_bus    = head_q.data;
	assign out_ch.hold_ms     = head_q.hold;
	assign out_ch.status      = head_q.status;
	assign out_ch.write_done  = head_q.done;
	assign out_ch.last_result = head_q.last;

endmodule

@@ design/char_lcd_bus_sequencer_top.sv @@
`timescale 1ns / 1ps

// Character LCD bus sequencer for an 8-bit write-only parallel character panel. Each
// transfer on in_ch is a tick, a text character or a clear request; each gives one
// pin-state result on out_ch, except the first tick, which gives the seven-result
// power-up run (40 ms wait, then function set, display on and clear pulses), and
// the unused opcode, which gives none. Characters are stored in a BUFFER_DEPTH
// entry memory (extra ones are dropped) and sent one per E pulse on later ticks.
// A new transfer is taken every clock cycle while the output buffer has room; only
// the power-up tick holds the control stage until all seven of its results are
// queued, and the next transfer waits for that. A transfer's result is registered
// twice: in the control stage, with the buffer read beside it, then in the two-entry
// output buffer, which keeps the input open while results wait.
// The user writes notify_enable through cfg_we/cfg_wdata only while the block is idle; the block does not enforce this.
module char_lcd_bus_sequencer_top import lcdseq_pkg::*; #(
	parameter int BUFFER_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	lcdseq_in_if.sink    in_ch,
	lcdseq_out_if.source out_ch,
	input  logic         cfg_we,
	input  logic         cfg_wdata
);

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	logic          valid_s1;
	lcdseq_rec_t   rec_s1;
	logic          take_s1;

	lcdseq_ctrl #(.DEPTH(BUFFER_DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.valid_s1  (valid_s1),
		.rec_s1    (rec_s1),
		.take_s1   (take_s1)
	);

	lcdseq_buf #(.DEPTH(BUFFER_DEPTH)) u_buf (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	lcdseq_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.rec_s1    (rec_s1),
		.mem_rdata (mem_rdata),
		.take_s1   (take_s1),
		.out_ch    (out_ch)
	);

	// a buffer read is only issued for a transfer that the control stage takes
	a_read_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (in_ch.valid && in_ch.ready && !mem_we))
		else $error("buffer read without a taken tick");

	// a data-sourced item raises E with RS high
	a_mem_item_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rec_s1.data_sel == DSEL_MEM) |-> (rec_s1.rs && rec_s1.e))
		else $error("character item without RS and E high");

	// only the power-up run gives non-final results, each with a hold time
	a_run_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.last_result) |-> (out_ch.hold_ms != 6'd0))
		else $error("non-final result without hold time");

	// a refused request or a done flag never comes with a hold time
	a_flag_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.status || out_ch.write_done))
			|-> (out_ch.hold_ms == 6'd0 && out_ch.last_result))
		else $error("flagged result with hold time");

endmodule
